// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is active
`define ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// clocked implication, disabled while reset is active
`define ASSERT_IMPL(lbl, clk_sig, rst_n_sig, ante, cons, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/dpb_pkg.sv -----
// ----------------------------------------------------------------------------
// dpb_pkg
// Shared widths, register map, reset values and types of the depth pixel
// back-projection block.
// ----------------------------------------------------------------------------
package dpb_pkg;

	// field widths
	localparam int PIX_W   = 12;
	localparam int DEPTH_W = 16;
	localparam int CTR_W   = 16;
	localparam int INV_W   = 24;
	localparam int COORD_W = 32;
	localparam int OFS_W   = 16;                 // |pixel q.4 - center q12.4|
	localparam int MZ_W    = OFS_W + DEPTH_W;    // offset * depth
	localparam int PROD_W  = MZ_W + INV_W;       // offset * depth * 1/f, q.28
	localparam int FRAC_SHIFT = 20;              // q.28 -> q.8
	localparam int RND_W   = PROD_W + 1;
	localparam int Q8_W    = RND_W - FRAC_SHIFT;

	// configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_INV_FOCAL_X = 3'd0,
		REG_INV_FOCAL_Y = 3'd1,
		REG_CENTER_X    = 3'd2,
		REG_CENTER_Y    = 3'd3,
		REG_DEPTH_LIMIT = 3'd4
	} reg_idx_t;

	// reset values
	localparam logic [INV_W-1:0]   RST_INV_FOCAL_X = 24'd27962;
	localparam logic [INV_W-1:0]   RST_INV_FOCAL_Y = 24'd27962;
	localparam logic [CTR_W-1:0]   RST_CENTER_X    = 16'd5120;
	localparam logic [CTR_W-1:0]   RST_CENTER_Y    = 16'd3840;
	localparam logic [DEPTH_W-1:0] RST_DEPTH_LIMIT = 16'd2000;

	// saturation bounds
	localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		logic [INV_W-1:0]   inv_focal_x;
		logic [INV_W-1:0]   inv_focal_y;
		logic [CTR_W-1:0]   center_x;
		logic [CTR_W-1:0]   center_y;
		logic [DEPTH_W-1:0] depth_limit;
	} cfg_t;

endpackage

// ----- hw/rtl/dpb_cfg.sv -----
// ----------------------------------------------------------------------------
// dpb_cfg
// Configuration register file behind the apb-style port.
// ----------------------------------------------------------------------------
module dpb_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dpb_pkg::ADDR_W-1:0]   paddr,
	input  logic [dpb_pkg::DATA_W-1:0]   pwdata,
	output logic [dpb_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output dpb_pkg::cfg_t                cfg
);
	import dpb_pkg::*;

	cfg_t             cfg_q;
	logic             wr_en;
	logic [IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	// register write on the access phase of a write transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_focal_x <= RST_INV_FOCAL_X;
			cfg_q.inv_focal_y <= RST_INV_FOCAL_Y;
			cfg_q.center_x    <= RST_CENTER_X;
			cfg_q.center_y    <= RST_CENTER_Y;
			cfg_q.depth_limit <= RST_DEPTH_LIMIT;
		end else if (wr_en) begin
			unique case (idx)
				REG_INV_FOCAL_X: cfg_q.inv_focal_x <= pwdata[INV_W-1:0];
				REG_INV_FOCAL_Y: cfg_q.inv_focal_y <= pwdata[INV_W-1:0];
				REG_CENTER_X:    cfg_q.center_x    <= pwdata[CTR_W-1:0];
				REG_CENTER_Y:    cfg_q.center_y    <= pwdata[CTR_W-1:0];
				REG_DEPTH_LIMIT: cfg_q.depth_limit <= pwdata[DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_INV_FOCAL_X: prdata = DATA_W'(cfg_q.inv_focal_x);
			REG_INV_FOCAL_Y: prdata = DATA_W'(cfg_q.inv_focal_y);
			REG_CENTER_X:    prdata = DATA_W'(cfg_q.center_x);
			REG_CENTER_Y:    prdata = DATA_W'(cfg_q.center_y);
			REG_DEPTH_LIMIT: prdata = DATA_W'(cfg_q.depth_limit);
			default:         prdata = '0;
		endcase
	end

endmodule

// ----- hw/rtl/dpb_axis.sv -----
// ----------------------------------------------------------------------------
// dpb_axis
// One axis of the back-projection: (pixel - center) * depth * 1/f, rounded
// to q.8 and saturated. Three register stages (s2..s4).
// ----------------------------------------------------------------------------
module dpb_axis (
	input  logic                               clk,
	input  logic        [dpb_pkg::PIX_W-1:0]   pix,
	input  logic        [dpb_pkg::CTR_W-1:0]   ctr,
	input  logic        [dpb_pkg::INV_W-1:0]   inv,
	input  logic        [dpb_pkg::DEPTH_W-1:0] depth,
	output logic signed [dpb_pkg::COORD_W-1:0] coord
);
	import dpb_pkg::*;

	logic [OFS_W-1:0]   p4;
	logic               neg;
	logic [OFS_W-1:0]   mag;
	logic [MZ_W-1:0]    mz_s2;
	logic               neg_s2;
	logic [PROD_W-1:0]  prod_s3;
	logic               neg_s3;
	logic [RND_W-1:0]   rnd;
	logic [Q8_W-1:0]    q8;
	logic [COORD_W-1:0] sat;
	logic [COORD_W-1:0] coord_s4;

	// offset from principal point, sign and magnitude in q.4
	assign p4  = {pix, 4'b0000};
	assign neg = p4 < ctr;
	assign mag = neg ? (ctr - p4) : (p4 - ctr);

	// s2: offset times depth
	always_ff @(posedge clk) begin
		mz_s2  <= MZ_W'(mag) * MZ_W'(depth);
		neg_s2 <= neg;
	end

	// s3: times reciprocal focal length
	always_ff @(posedge clk) begin
		prod_s3 <= PROD_W'(mz_s2) * PROD_W'(inv);
		neg_s3  <= neg_s2;
	end

	// round half away from zero on the magnitude, then saturate
	assign rnd = RND_W'(prod_s3) + (RND_W'(1) << (FRAC_SHIFT - 1));
	assign q8  = rnd[RND_W-1:FRAC_SHIFT];

	always_comb begin
		if (neg_s3) begin
			if (q8 >= Q8_W'(COORD_MIN))
				sat = COORD_MIN;
			else
				sat = COORD_W'(0) - q8[COORD_W-1:0];
		end else begin
			if (q8 > Q8_W'(COORD_MAX))
				sat = COORD_MAX;
			else
				sat = q8[COORD_W-1:0];
		end
	end

	// s4: result register
	always_ff @(posedge clk) begin
		coord_s4 <= sat;
	end

	assign coord = signed'(coord_s4);

endmodule

// ----- hw/rtl/depth_pixel_backprojection.sv -----
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// Pinhole back-projection of one depth pixel to a camera-frame 3-D point.
// ----------------------------------------------------------------------------
// The block takes one pixel every clock cycle: busy is always low, and a
// pixel given with start appears on the result ports with done after the
// input register, offset-times-depth multiply, reciprocal multiply and
// round-and-saturate stages. Results are never held back, so the
// receiver must take done whenever it is high. Depths of zero or above
// depth_limit give the point (0,0,0) with point_valid low. Registers are to
// be written only while no pixel is in flight.
module depth_pixel_backprojection (
	input  logic                               clk,
	input  logic                               arst_n,
	// command channel
	input  logic                               start,
	output logic                               busy,
	input  logic        [dpb_pkg::PIX_W-1:0]   pixel_column,
	input  logic        [dpb_pkg::PIX_W-1:0]   pixel_row,
	input  logic        [dpb_pkg::DEPTH_W-1:0] depth_mm,
	// result channel
	output logic                               done,
	output logic signed [dpb_pkg::COORD_W-1:0] point_x,
	output logic signed [dpb_pkg::COORD_W-1:0] point_y,
	output logic        [dpb_pkg::DEPTH_W-1:0] point_z,
	output logic                               point_valid,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic        [dpb_pkg::ADDR_W-1:0]  paddr,
	input  logic        [dpb_pkg::DATA_W-1:0]  pwdata,
	output logic        [dpb_pkg::DATA_W-1:0]  prdata,
	output logic                               pready
);
	import dpb_pkg::*;

	cfg_t                       cfg;
	logic                       accept;
	logic                       valid_s1, valid_s2, valid_s3, valid_s4;
	logic                       ok_s1, ok_s2, ok_s3, ok_s4;
	logic [PIX_W-1:0]           col_s1, row_s1;
	logic [DEPTH_W-1:0]         z_s1, z_s2, z_s3, z_s4;
	logic signed [COORD_W-1:0]  x_coord, y_coord;
	logic                       show;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// configuration registers
	dpb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// valid bits travel with the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// s1: capture the pixel
	always_ff @(posedge clk) begin
		col_s1 <= pixel_column;
		row_s1 <= pixel_row;
		z_s1   <= depth_mm;
	end

	// depth range check alongside the multiplies
	always_ff @(posedge clk) begin
		ok_s2 <= ok_s1;
		ok_s3 <= ok_s2;
		ok_s4 <= ok_s3;
		z_s2  <= z_s1;
		z_s3  <= z_s2;
		z_s4  <= z_s3;
	end

	assign ok_s1 = (z_s1 != '0) && (z_s1 <= cfg.depth_limit);

	// per-axis datapaths
	dpb_axis u_axis_x (
		.clk   (clk),
		.pix   (col_s1),
		.ctr   (cfg.center_x),
		.inv   (cfg.inv_focal_x),
		.depth (z_s1),
		.coord (x_coord)
	);

	dpb_axis u_axis_y (
		.clk   (clk),
		.pix   (row_s1),
		.ctr   (cfg.center_y),
		.inv   (cfg.inv_focal_y),
		.depth (z_s1),
		.coord (y_coord)
	);

	// result outputs, zero point for rejected depths
	assign show        = valid_s4 & ok_s4;
	assign done        = valid_s4;
	assign point_valid = show;
	assign point_x     = show ? x_coord : '0;
	assign point_y     = show ? y_coord : '0;
	assign point_z     = show ? z_s4 : '0;

endmodule

// ----- hw/rtl/dpb_checker.sv -----
// ----------------------------------------------------------------------------
// dpb_checker
// Port-level checks of the back-projection block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpb_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic        [dpb_pkg::DEPTH_W-1:0] depth_mm,
	input  logic                               done,
	input  logic signed [dpb_pkg::COORD_W-1:0] point_x,
	input  logic signed [dpb_pkg::COORD_W-1:0] point_y,
	input  logic        [dpb_pkg::DEPTH_W-1:0] point_z,
	input  logic                               point_valid
);
	import dpb_pkg::*;

	// every accepted pixel gives a result with done
	`ASSERT_IMPL(a_latency, clk, arst_n, start && !busy, ##4 done, "missing result")

	// no result without an earlier accepted transfer
	`ASSERT_IMPL(a_no_spurious, clk, arst_n, done, $past(start && !busy, 4), "spurious result")

	// rejected depths give the zero point
	`ASSERT_IMPL(a_zero_point, clk, arst_n, done && !point_valid,
		point_x == '0 && point_y == '0 && point_z == '0, "nonzero invalid point")

	// z of a valid point is the depth of the pixel
	`ASSERT_IMPL(a_z_match, clk, arst_n, done && point_valid,
		point_z == $past(depth_mm, 4) && point_z != '0, "z does not match depth")

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.depth_mm    (depth_mm),
	.done        (done),
	.point_x     (point_x),
	.point_y     (point_y),
	.point_z     (point_z),
	.point_valid (point_valid)
);
